### sv/pcs_pkg.sv
// Shared types and constants for the palette colour swap block.
package pcs_pkg;

    localparam int COLOR_W = 32;
    localparam int SLOT_W  = 4;
    localparam int ACT_W   = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_ACTIVE_ENTRIES = 3'd0;

    // Word travelling down the cell chain. For a load, col_a/col_b carry the
    // old/new colours; for a pixel, col_a is the input and col_b the result.
    typedef struct packed {
        logic              vld;
        logic              func;
        logic [SLOT_W-1:0] idx;
        logic [COLOR_W-1:0] col_a;
        logic [COLOR_W-1:0] col_b;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } pcs_tok_t;

endpackage

### sv/palette_color_swap.sv
// Top level of the palette colour swap block: config port and cell chain.
// Palette colour swap. Every word (load or pixel) enters a chain of
// PALETTE_ENTRIES cells, one cell per palette slot, and moves one cell per
// cycle while the chain advances; a word is accepted every cycle the result
// side is not stalled, so throughput is one word per clock. A pixel result
// is registered in each cell in turn and is valid on the output from the
// last cell's register; a stalled result freezes the whole chain. Loads
// travel the chain too and write their slot on the way, so pixels and loads
// keep their order. Loads give no result. The active_entries register (byte
// address 0) is to be written only while the block is idle.
module palette_color_swap #(
    parameter int PALETTE_ENTRIES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcs_pkg::ADDR_W-1:0]    paddr,
    input  logic [pcs_pkg::DATA_W-1:0]    pwdata,
    output logic [pcs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // Input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [pcs_pkg::SLOT_W-1:0]    s_entry_index,
    input  logic [pcs_pkg::COLOR_W-1:0]   s_old_color,
    input  logic [pcs_pkg::COLOR_W-1:0]   s_new_color,
    input  logic [pcs_pkg::COLOR_W-1:0]   s_pixel_in,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pcs_pkg::COLOR_W-1:0]   m_pixel_out,
    output logic                          m_matched,
    output logic [pcs_pkg::SLOT_W-1:0]    m_match_slot
);
    import pcs_pkg::*;

    logic [ACT_W-1:0] active_reg;
    logic             cfg_wr;
    logic             sel_active;
    logic             adv;
    pcs_tok_t         chain [0:PALETTE_ENTRIES];

    // Register write and read-back; byte lanes within a register ignored
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign sel_active = (paddr[ADDR_W-1:2] == ADDR_ACTIVE_ENTRIES[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (cfg_wr && sel_active) begin
            active_reg <= pwdata[ACT_W-1:0];
        end
    end

    assign prdata = sel_active ? {{(DATA_W-ACT_W){1'b0}}, active_reg} : '0;

    // Chain advances unless a result waits untaken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Entry word
    assign chain[0] = '{
        vld:   s_valid,
        func:  s_func,
        idx:   s_entry_index,
        col_a: (s_func == FUNC_LOAD) ? s_old_color : s_pixel_in,
        col_b: (s_func == FUNC_LOAD) ? s_new_color : s_pixel_in,
        hit:   1'b0,
        slot:  '0
    };

    // Cell row
    for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
        pcs_cell #(
            .CELL_ID(k)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .adv           (adv),
            .active_entries(active_reg),
            .tok_i         (chain[k]),
            .tok_o         (chain[k+1])
        );
    end

    // Last cell's register is the output register; loads drop out here
    assign m_valid      = chain[PALETTE_ENTRIES].vld
                          && (chain[PALETTE_ENTRIES].func == FUNC_PIXEL);
    assign m_pixel_out  = chain[PALETTE_ENTRIES].col_b;
    assign m_matched    = chain[PALETTE_ENTRIES].hit;
    assign m_match_slot = chain[PALETTE_ENTRIES].slot;

`ifndef ASSERT_OFF
    // No hit means slot reads zero
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_matched) |-> (m_match_slot == '0))
        else $error("match_slot nonzero without a match");

    // A miss passes the input pixel through
    a_miss_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_matched) |-> (m_pixel_out == chain[PALETTE_ENTRIES].col_a))
        else $error("unmatched pixel altered");

    // A stalled result blocks new input
    a_stall_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result stalled");

    // Register write lands
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && sel_active) |=>
            (active_reg == $past(pwdata[ACT_W-1:0])))
        else $error("active_entries write lost");
`endif

endmodule

### sv/pcs_cell.sv
// One palette cell: holds a single colour pair and compares passing pixels.
module pcs_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic [pcs_pkg::ACT_W-1:0] active_entries,
    input  pcs_pkg::pcs_tok_t        tok_i,
    output pcs_pkg::pcs_tok_t        tok_o
);
    import pcs_pkg::*;

    // Only the first sixteen slots are reachable by a 4-bit index
    localparam bit ADDRESSABLE = (CELL_ID < (1 << SLOT_W));

    logic [COLOR_W-1:0] old_reg;
    logic [COLOR_W-1:0] new_reg;
    logic               written_reg;
    pcs_tok_t           tok_reg;
    pcs_tok_t           tok_next;
    logic               is_active;
    logic               load_here;

    assign is_active = ({27'd0, active_entries} > 32'(CELL_ID));
    assign load_here = ADDRESSABLE && tok_i.vld && (tok_i.func == FUNC_LOAD)
                       && (tok_i.idx == SLOT_W'(CELL_ID));

    // Compare and substitute on the first hit only
    always_comb begin
        tok_next = tok_i;
        if ((tok_i.func == FUNC_PIXEL) && !tok_i.hit && written_reg && is_active
            && (old_reg == tok_i.col_a)) begin
            tok_next.col_b = new_reg;
            tok_next.hit   = 1'b1;
            tok_next.slot  = SLOT_W'(CELL_ID);
        end
    end

    // Slot contents and hand-over register; only the valid bits are reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= 1'b0;
            tok_reg.vld <= 1'b0;
        end else if (adv) begin
            tok_reg <= tok_next;
            if (load_here) begin
                written_reg <= 1'b1;
                old_reg     <= tok_i.col_a;
                new_reg     <= tok_i.col_b;
            end
        end
    end

    assign tok_o = tok_reg;

endmodule

### dv/tb.sv
// Self-checking testbench for the palette colour swap block.
`timescale 1ns / 1ps

module tb;
    import pcs_pkg::*;

    localparam int ENTRIES      = 16;
    // Chain length plus margin: lets loads still in flight settle
    localparam int DRAIN_CYCLES = 40;

    // One predicted result word
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
    } swap_word_t;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic                s_func;
    logic [SLOT_W-1:0]   s_entry_index;
    logic [COLOR_W-1:0]  s_old_color;
    logic [COLOR_W-1:0]  s_new_color;
    logic [COLOR_W-1:0]  s_pixel_in;
    logic                m_valid;
    logic                m_ready;
    logic [COLOR_W-1:0]  m_pixel_out;
    logic                m_matched;
    logic [SLOT_W-1:0]   m_match_slot;

    palette_color_swap #(
        .PALETTE_ENTRIES(ENTRIES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_entry_index (s_entry_index),
        .s_old_color   (s_old_color),
        .s_new_color   (s_new_color),
        .s_pixel_in    (s_pixel_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_matched     (m_matched),
        .m_match_slot  (m_match_slot)
    );

    // Shadow palette and register
    logic [COLOR_W-1:0] palette_old [ENTRIES];
    logic [COLOR_W-1:0] palette_new [ENTRIES];
    bit                 palette_written [ENTRIES];
    logic [ACT_W-1:0]   active_cfg;

    swap_word_t pending_swaps[$];

    int mismatches;
    int results_seen;
    int loads_sent;
    int pixels_sent;
    int hits_predicted;
    int settings_used;
    int send_idle_pct;
    int recv_idle_pct;

    always #2 aclk = ~aclk;

    // Safety net against a hung handshake
    initial begin
        #2_000_000;
        $display("** palette_color_swap: FAILED **");
        $finish;
    end

    // Recolour one pixel against the shadow palette
    function automatic swap_word_t predict_swap(input logic [COLOR_W-1:0] pix);
        swap_word_t r;
        int         lim;
        r.color = pix;
        r.hit   = 1'b0;
        r.slot  = '0;
        lim = (active_cfg > ENTRIES) ? ENTRIES : int'(active_cfg);
        for (int p = 0; p < lim; p++) begin
            if (palette_written[p] && palette_old[p] == pix) begin
                r.color = palette_new[p];
                r.hit   = 1'b1;
                r.slot  = p[SLOT_W-1:0];
                break;
            end
        end
        return r;
    endfunction

    // Result checker
    always @(posedge aclk) begin : result_check
        swap_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_swaps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: pixel_out %h matched %b slot %0d",
                             m_pixel_out, m_matched, m_match_slot);
            end else begin
                want = pending_swaps.pop_front();
                results_seen++;
                if (m_pixel_out !== want.color || m_matched !== want.hit ||
                    m_match_slot !== want.slot) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                                 want.color, want.hit, want.slot,
                                 m_pixel_out, m_matched, m_match_slot);
                end
            end
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drive one word, wait for its acceptance, then update the prediction
    task automatic send_word(input logic f, input logic [SLOT_W-1:0] idx,
                             input logic [COLOR_W-1:0] oc, input logic [COLOR_W-1:0] nc,
                             input logic [COLOR_W-1:0] pix);
        swap_word_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_func        = f;
        s_entry_index = idx;
        s_old_color   = oc;
        s_new_color   = nc;
        s_pixel_in    = pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (f == FUNC_LOAD) begin
            palette_old[idx]     = oc;
            palette_new[idx]     = nc;
            palette_written[idx] = 1'b1;
            loads_sent++;
        end else begin
            r = predict_swap(pix);
            pending_swaps.push_back(r);
            pixels_sent++;
            if (r.hit) hits_predicted++;
        end
        @(negedge aclk);
    endtask

    task automatic load_pair(input int idx, input logic [COLOR_W-1:0] oc,
                             input logic [COLOR_W-1:0] nc);
        send_word(FUNC_LOAD, idx[SLOT_W-1:0], oc, nc, $urandom);
    endtask

    task automatic send_pixel(input logic [COLOR_W-1:0] pix);
        send_word(FUNC_PIXEL, SLOT_W'($urandom_range(ENTRIES-1)), $urandom, $urandom, pix);
    endtask

    // Hold the sender until every result is back and the chain is empty
    task automatic wait_until_drained();
        s_valid = 1'b0;
        while (pending_swaps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Idle the block, write active_entries and read it back
    task automatic set_active(input int value);
        logic [DATA_W-1:0] wdata;
        logic [DATA_W-1:0] got;
        wait_until_drained();
        wdata = $urandom;
        wdata[ACT_W-1:0] = value[ACT_W-1:0];
        // write: setup then access
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_ACTIVE_ENTRIES;
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        active_cfg = wdata[ACT_W-1:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        // read back
        psel    = 1'b1;
        paddr   = ADDR_ACTIVE_ENTRIES;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== DATA_W'(active_cfg)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register readback: expected %h, got %h",
                         DATA_W'(active_cfg), got);
        end
        settings_used++;
    endtask

    // Nothing loaded yet: every pixel passes straight through
    task automatic test_unwritten_entries();
        send_pixel(32'h0000_0000);
        set_active(ENTRIES);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel($urandom);
    endtask

    // Priority of the lowest slot, overwrite, exact RGBA compare
    task automatic test_first_match();
        load_pair(0, 32'h0000_0000, 32'hFFFF_FFFF);
        load_pair(ENTRIES-1, 32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        load_pair(3, 32'h0000_0000, 32'hA5A5_A5A5);
        send_pixel(32'h0000_0000);
        load_pair(0, 32'h1122_3344, 32'h5566_7788);
        send_pixel(32'h0000_0000);
        send_pixel(32'h1122_3344);
        // one byte off, or bytes swapped: no match
        send_pixel(32'h1122_3345);
        send_pixel(32'h9122_3344);
        send_pixel(32'h4433_2211);
    endtask

    // active_entries bounds, including saturation above the table size
    task automatic test_active_limit();
        set_active(0);
        send_pixel(32'hFFFF_FFFF);
        set_active(31);
        send_pixel(32'hFFFF_FFFF);
        set_active(ENTRIES-1);
        send_pixel(32'hFFFF_FFFF);
        set_active(1);
        send_pixel(32'h1122_3344);
        send_pixel(32'h0000_0000);
    endtask

    function automatic int pick_setting();
        case ($urandom_range(7))
            0: return 0;
            1: return ENTRIES;
            2: return 31;
            3: return 1;
            4: return $urandom_range(31, ENTRIES+1);
            default: return $urandom_range(ENTRIES-1, 2);
        endcase
    endfunction

    // One random word, mostly pixels aimed at loaded colours
    task automatic random_word();
        logic [SLOT_W-1:0]  idx;
        logic [COLOR_W-1:0] oc;
        logic [COLOR_W-1:0] nc;
        logic [COLOR_W-1:0] pix;
        int                 pick;
        int                 src;
        idx  = SLOT_W'($urandom_range(ENTRIES-1));
        oc   = $urandom;
        nc   = $urandom;
        pix  = $urandom;
        pick = $urandom_range(99);
        src  = $urandom_range(ENTRIES-1);
        if (pick < 25) begin
            // duplicate colours exercise first-match priority
            if ($urandom_range(3) == 0 && palette_written[src])
                oc = palette_old[src];
            else if ($urandom_range(7) == 0)
                oc = $urandom_range(1) ? '1 : '0;
            send_word(FUNC_LOAD, idx, oc, nc, pix);
        end else begin
            if (pick < 70 && palette_written[src])
                pix = palette_old[src];
            else if (pick < 82 && palette_written[src])
                pix = palette_old[src] ^ (32'h1 << $urandom_range(31));
            else if (pick < 86)
                pix = $urandom_range(1) ? '1 : '0;
            send_word(FUNC_PIXEL, idx, oc, nc, pix);
        end
    endtask

    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) set_active(pick_setting());
            else if (i == n / 3) wait_until_drained();
            random_word();
        end
        s_valid = 1'b0;
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_func        = FUNC_LOAD;
        s_entry_index = '0;
        s_old_color   = '0;
        s_new_color   = '0;
        s_pixel_in    = '0;
        m_ready       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        active_cfg    = '0;
        for (int i = 0; i < ENTRIES; i++) palette_written[i] = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_unwritten_entries();
        test_first_match();
        test_active_limit();
        test_random_traffic(600, 34, 63);
        test_random_traffic(600, 63, 34);
        test_random_traffic(600, 0, 0);
        wait_until_drained();

        $display("Run covered %0d palette loads and %0d pixels (%0d predicted hits).",
                 loads_sent, pixels_sent, hits_predicted);
        $display("%0d results checked over %0d active_entries settings, %0d mismatches.",
                 results_seen, settings_used, mismatches);
        if (mismatches == 0) begin
            $display("** palette_color_swap: PASSED **");
        end else begin
            $display("** palette_color_swap: FAILED **");
        end
        $finish;
    end

endmodule

### palette_color_swap.f
sv/pcs_pkg.sv
sv/pcs_cell.sv
sv/palette_color_swap.sv
dv/tb.sv
